// ===== rtl/tcp_response_fingerprint_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher: assertion macros
// Shared property forms for the matcher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TCP_RESPONSE_FINGERPRINT_MATCHER_MACROS_SVH
`define TCP_RESPONSE_FINGERPRINT_MATCHER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define TRFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on the edge after any reset cycle.
`define TRFM_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/trfm_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher package
// Item, result, command and configuration types with fixed constants.
// ----------------------------------------------------------------------------
package trfm_pkg;

  localparam int PORT_W      = 16;
  localparam int SEQ_W       = 32;
  localparam int WIN_W       = 16;
  localparam int FLAG_W      = 8;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 8;
  localparam int SIG_NUM_W   = 10;
  localparam int ACK_CODE_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int ACK_BASE   = 1000;
  localparam int ACK_RANDOM = ACK_BASE + 666;

  localparam int CMD_QUEUE_DEPTH    = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

  localparam logic [PORT_W-1:0] BASE_PORT_RESET   = 16'd4000;
  localparam logic [PORT_W-1:0] TARGET_PORT_RESET = 16'd80;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_REPLY  = 3'd1,
    KIND_HEADER = 3'd2,
    KIND_ENTRY  = 3'd3,
    KIND_BLANK  = 3'd4,
    KIND_BAD    = 3'd5,
    KIND_END    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_IDENTIFIED = 2'd0,
    VERDICT_INACCURATE = 2'd1,
    VERDICT_UNKNOWN    = 2'd2
  } verdict_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_PORT   = 2'd0,
    CFG_TARGET_PORT = 2'd1,
    CFG_INIT_SEQ    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic [SEQ_W-1:0]  seq_number;
    logic [SEQ_W-1:0]  ack_number;
    logic [WIN_W-1:0]  window;
    logic [FLAG_W-1:0] tcp_flags;
    logic [PORT_W-1:0] urgent;
    logic [SLOT_W-1:0] slot;
    logic              name_inaccurate;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           verdict;
    logic [SIG_NUM_W-1:0] signature_number;
  } result_t;

  typedef struct packed {
    logic [PORT_W-1:0] base_port;
    logic [PORT_W-1:0] target_port;
    logic [SEQ_W-1:0]  initial_sequence;
  } cfg_t;

  // Classified item: reply fields already reduced to what a slot record holds,
  // entry fields reduced to legality flags plus the narrow compare values.
  typedef struct packed {
    kind_t                 op;
    logic [SLOT_W-1:0]     slot;
    logic                  slot_ok;
    logic                  seq_bit;
    logic                  seq_legal;
    logic [ACK_CODE_W-1:0] ack_code;
    logic                  ack_exact;
    logic                  ack_legal;
    logic [WIN_W-1:0]      window;
    logic [FLAG_W-1:0]     flags;
    logic                  urgent_bit;
    logic                  inaccurate;
  } cmd_t;

endpackage

// ===== rtl/trfm_queue.sv =====
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher: small queue
// Register-based first-in first-out buffer for commands and results.
// ----------------------------------------------------------------------------
module trfm_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wdata,
  output logic  full,
  input  logic  rd_en,
  output item_t rdata,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/trfm_front.sv =====
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher: front end
// Classify each request, map replies to slots, reduce acks to codes.
// ----------------------------------------------------------------------------
module trfm_front #(
  parameter int PROBE_SLOTS = 7
) (
  input  trfm_pkg::in_item_t item,
  input  trfm_pkg::cfg_t     cfg,
  output trfm_pkg::cmd_t     cmd,
  output logic               keep
);

  import trfm_pkg::*;

  logic [PORT_W:0]       port_diff;
  logic                  reply_in_range;
  logic                  reply_from_target;
  logic [SEQ_W-1:0]      ack_sum;
  logic [ACK_CODE_W-1:0] reply_code;
  logic                  is_reply;
  logic                  ack_ge_base;

  assign is_reply = (item.kind == KIND_REPLY);

  // Slot number is dst - base; negative differences fall out through the borrow.
  assign port_diff         = {1'b0, item.dst_port} - {1'b0, cfg.base_port};
  assign reply_in_range    = !port_diff[PORT_W] &&
                             (port_diff[PORT_W-1:0] < PORT_W'(PROBE_SLOTS));
  assign reply_from_target = (item.src_port == cfg.target_port);

  // Ack code: zero ack stays zero, otherwise offset and saturate at random.
  assign ack_sum     = item.ack_number - cfg.initial_sequence + SEQ_W'(ACK_BASE);
  assign reply_code  = (item.ack_number == '0) ? '0 :
                       (ack_sum > SEQ_W'(ACK_RANDOM)) ? ACK_CODE_W'(ACK_RANDOM) :
                       ack_sum[ACK_CODE_W-1:0];
  assign ack_ge_base = (item.ack_number >= SEQ_W'(ACK_BASE));

  always_comb begin
    cmd            = '0;
    cmd.op         = kind_t'(item.kind);
    cmd.window     = item.window;
    cmd.flags      = item.tcp_flags;
    cmd.urgent_bit = (item.urgent != '0);
    cmd.inaccurate = item.name_inaccurate;
    if (is_reply) begin
      cmd.slot      = port_diff[SLOT_W-1:0];
      cmd.slot_ok   = reply_in_range;
      cmd.seq_bit   = (item.seq_number != '0);
      cmd.seq_legal = 1'b1;
      cmd.ack_code  = reply_code;
      cmd.ack_exact = 1'b1;
      cmd.ack_legal = 1'b1;
    end else begin
      cmd.slot      = item.slot;
      cmd.slot_ok   = ({1'b0, item.slot} < (SLOT_W + 1)'(PROBE_SLOTS));
      cmd.seq_bit   = item.seq_number[0];
      cmd.seq_legal = (item.seq_number[SEQ_W-1:1] == '0);
      cmd.ack_code  = item.ack_number[ACK_CODE_W-1:0];
      cmd.ack_exact = ack_ge_base;
      // Exact codes above the code width can never equal a stored code.
      cmd.ack_legal = ack_ge_base ? (item.ack_number[SEQ_W-1:ACK_CODE_W] == '0)
                                  : (item.ack_number[SEQ_W-1:1] == '0);
    end
  end

  // Drop the unused kind code, and replies not from the target port or outside the slots.
  always_comb begin
    case (item.kind)
      KIND_REPLY:  keep = reply_from_target && reply_in_range;
      KIND_CLEAR,
      KIND_HEADER,
      KIND_ENTRY,
      KIND_BLANK,
      KIND_BAD,
      KIND_END:    keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

endmodule

// ===== rtl/trfm_back.sv =====
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher: back end
// Slot records and signature match state; issue verdicts.
// ----------------------------------------------------------------------------
module trfm_back #(
  parameter int PROBE_SLOTS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  trfm_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               out_full,
  output logic               res_push,
  output trfm_pkg::result_t  res
);

  import trfm_pkg::*;

  localparam int IDX_W = (PROBE_SLOTS > 1) ? $clog2(PROBE_SLOTS) : 1;

  logic [PROBE_SLOTS-1:0] slot_valid;
  logic [PROBE_SLOTS-1:0] slot_valid_next;
  logic                   slot_seq_nonzero [PROBE_SLOTS];
  logic [ACK_CODE_W-1:0]  slot_ack_code    [PROBE_SLOTS];
  logic [WIN_W-1:0]       slot_window      [PROBE_SLOTS];
  logic [FLAG_W-1:0]      slot_flags       [PROBE_SLOTS];
  logic                   slot_urgent      [PROBE_SLOTS];

  logic                 sig_active, sig_active_next;
  logic [COUNT_W-1:0]   entries_matched, entries_matched_next;
  logic [COUNT_W-1:0]   entries_seen, entries_seen_next;
  logic                 header_inaccurate, header_inaccurate_next;
  logic [SIG_NUM_W-1:0] header_count, header_count_next;
  logic                 verdict_given, verdict_given_next;

  logic [IDX_W-1:0] idx;
  logic             rec_write;
  logic             ack_ok;
  logic             win_ok;
  logic             seq_ok;
  logic             rec_match;
  logic             entry_hit;

  // Stall the whole back end while the result queue has no room.
  assign cmd_pop = !cmd_empty && !out_full;
  assign idx     = cmd.slot[IDX_W-1:0];

  assign ack_ok    = cmd.ack_legal &&
                     (cmd.ack_exact ? (cmd.ack_code == slot_ack_code[idx])
                                    : (cmd.ack_code[0] == (slot_ack_code[idx] != '0)));
  assign win_ok    = (cmd.window == slot_window[idx]) ||
                     ((cmd.window == WIN_W'(1)) && (slot_window[idx] != '0));
  assign seq_ok    = cmd.seq_legal && (cmd.seq_bit == slot_seq_nonzero[idx]);
  assign rec_match = ack_ok && seq_ok && win_ok &&
                     (cmd.flags == slot_flags[idx]) &&
                     (cmd.urgent_bit == slot_urgent[idx]);
  // A slot with no reply matches only an entry expecting no flags.
  assign entry_hit = cmd.slot_ok &&
                     (slot_valid[idx] ? rec_match : (cmd.flags == '0));

  always_comb begin
    slot_valid_next        = slot_valid;
    sig_active_next        = sig_active;
    entries_matched_next   = entries_matched;
    entries_seen_next      = entries_seen;
    header_inaccurate_next = header_inaccurate;
    header_count_next      = header_count;
    verdict_given_next     = verdict_given;
    rec_write              = 1'b0;
    res_push               = 1'b0;
    res                    = '0;
    if (cmd_pop) begin
      case (cmd.op)
        KIND_CLEAR: begin
          slot_valid_next        = '0;
          sig_active_next        = 1'b0;
          entries_matched_next   = '0;
          entries_seen_next      = '0;
          header_inaccurate_next = 1'b0;
          header_count_next      = '0;
          verdict_given_next     = 1'b0;
        end
        KIND_REPLY: begin
          // First reply per slot wins.
          if (cmd.slot_ok && !slot_valid[idx]) begin
            slot_valid_next[idx] = 1'b1;
            rec_write            = 1'b1;
          end
        end
        default: begin
          if (!verdict_given) begin
            case (cmd.op)
              KIND_HEADER: begin
                header_count_next      = header_count + SIG_NUM_W'(1);
                header_inaccurate_next = cmd.inaccurate;
                sig_active_next        = 1'b1;
                entries_matched_next   = '0;
                entries_seen_next      = '0;
              end
              KIND_ENTRY: begin
                entries_seen_next = entries_seen + COUNT_W'(1);
                if (entry_hit) begin
                  entries_matched_next = entries_matched + COUNT_W'(1);
                end else begin
                  entries_matched_next = '0;
                  sig_active_next      = 1'b0;
                end
              end
              KIND_BLANK: begin
                if (sig_active && (entries_matched == entries_seen)) begin
                  verdict_given_next   = 1'b1;
                  res_push             = 1'b1;
                  res.verdict          = header_inaccurate ? VERDICT_INACCURATE
                                                           : VERDICT_IDENTIFIED;
                  res.signature_number = header_count;
                end else begin
                  sig_active_next      = 1'b0;
                  entries_matched_next = '0;
                  entries_seen_next    = '0;
                end
              end
              KIND_BAD: begin
                sig_active_next      = 1'b0;
                entries_matched_next = '0;
                entries_seen_next    = '0;
              end
              KIND_END: begin
                verdict_given_next   = 1'b1;
                res_push             = 1'b1;
                res.verdict          = VERDICT_UNKNOWN;
                res.signature_number = header_count;
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rec_write) begin
      slot_seq_nonzero[idx] <= cmd.seq_bit;
      slot_ack_code[idx]    <= cmd.ack_code;
      slot_window[idx]      <= cmd.window;
      slot_flags[idx]       <= cmd.flags;
      slot_urgent[idx]      <= cmd.urgent_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid        <= '0;
      sig_active        <= 1'b0;
      entries_matched   <= '0;
      entries_seen      <= '0;
      header_inaccurate <= 1'b0;
      header_count      <= '0;
      verdict_given     <= 1'b0;
    end else begin
      slot_valid        <= slot_valid_next;
      sig_active        <= sig_active_next;
      entries_matched   <= entries_matched_next;
      entries_seen      <= entries_seen_next;
      header_inaccurate <= header_inaccurate_next;
      header_count      <= header_count_next;
      verdict_given     <= verdict_given_next;
    end
  end

endmodule

// ===== rtl/tcp_response_fingerprint_matcher.sv =====
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher
// Stores probe replies per slot and matches a signature stream against them.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: a request is taken on a clock
//   edge with push high and full low. Results leave through a queue-style
//   port: the oldest result sits on result while empty is low and is removed
//   on an edge with pop high. At most one result follows any request.
//   Configuration (base port, target port, initial sequence) is written on
//   the cfg channel, which is always ready; index 3 is accepted and dropped.
//   Write configuration only while no request is in flight.
// Timing:
//   One request per cycle, sustained while full is low. A result shows on the
//   result port once its request has passed through the command queue and
//   the back end's state update has written it into the result queue.
// Stalls:
//   When result is not popped the result queue fills, the back end holds and
//   the command queue fills behind it; full then rises. Two results and two
//   commands can be buffered.
// Reset:
//   rst clears both queues, all slot valid bits and the match state, and
//   loads base port 4000, target port 80 and initial sequence 0.
// ----------------------------------------------------------------------------
`include "tcp_response_fingerprint_matcher_macros.svh"

module tcp_response_fingerprint_matcher #(
  parameter int PROBE_SLOTS = 7
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  trfm_pkg::in_item_t                      item,
  output logic                                    empty,
  input  logic                                    pop,
  output trfm_pkg::result_t                       result,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [trfm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [trfm_pkg::CFG_DATA_W-1:0]         cfg_data
);

  import trfm_pkg::*;

  cfg_t    cfg;
  cmd_t    front_cmd;
  cmd_t    back_cmd;
  logic    front_keep;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_push;
  result_t res;
  logic    out_full;

  // Configuration registers; the channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_port        <= BASE_PORT_RESET;
      cfg.target_port      <= TARGET_PORT_RESET;
      cfg.initial_sequence <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_PORT:   cfg.base_port        <= cfg_data[PORT_W-1:0];
        CFG_TARGET_PORT: cfg.target_port      <= cfg_data[PORT_W-1:0];
        CFG_INIT_SEQ:    cfg.initial_sequence <= cfg_data[SEQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify the request; dropped requests never reach the queue.
  trfm_front #(
    .PROBE_SLOTS (PROBE_SLOTS)
  ) u_front (
    .item (item),
    .cfg  (cfg),
    .cmd  (front_cmd),
    .keep (front_keep)
  );

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && front_keep;

  // Decouple classification from the state update.
  trfm_queue #(
    .item_t (cmd_t),
    .DEPTH  (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cmd_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .rd_en (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  // Back end: slot records, signature counters and verdicts.
  trfm_back #(
    .PROBE_SLOTS (PROBE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result buffer; lets the back end run while the receiver holds off pop.
  trfm_queue #(
    .item_t (result_t),
    .DEPTH  (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (res_push),
    .wdata (res),
    .full  (out_full),
    .rd_en (pop),
    .rdata (result),
    .empty (empty)
  );

  `TRFM_ASSERT_AFTER_RESET(a_reset_drains, clk, rst, empty && !full, "queues not empty after reset")
  `TRFM_ASSERT_NOW(a_result_room, clk, rst, res_push, !out_full, "result pushed into a full queue")
  `TRFM_ASSERT_NOW(a_result_has_cmd, clk, rst, res_push, cmd_pop, "result without a command")
  `TRFM_ASSERT_NOW(a_cmd_from_request, clk, rst, cmd_push, push && !full, "command without a request")

endmodule

// ===== dv/tb_tcp_response_fingerprint_matcher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP response fingerprint matcher testbench
// Drives reply and signature requests through the push/full port, predicts
// every verdict with an in-bench model of the slot records and match state,
// and checks each popped result in order. Covers directed corner cases,
// register extremes, output back-pressure, counter wrap and random sessions.
// ----------------------------------------------------------------------------
module tb_tcp_response_fingerprint_matcher;
  import trfm_pkg::*;

  localparam int NUM_SLOTS       = 7;
  localparam int TIMEOUT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_ITEMS    = 580;

  // Kind 7 has no name in the package; the block ignores it.
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  // Index 3 of the cfg channel is taken and dropped.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  tcp_response_fingerprint_matcher #(
    .PROBE_SLOTS(NUM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Matcher model: register copies, per-slot reply records, signature state.
  // --------------------------------------------------------------------------
  logic [PORT_W-1:0]     base_port_reg;
  logic [PORT_W-1:0]     target_port_reg;
  logic [SEQ_W-1:0]      init_seq_reg;

  bit                    rec_valid    [NUM_SLOTS];
  bit                    rec_seq_set  [NUM_SLOTS];
  logic [ACK_CODE_W-1:0] rec_ack_code [NUM_SLOTS];
  logic [WIN_W-1:0]      rec_win      [NUM_SLOTS];
  logic [FLAG_W-1:0]     rec_flags    [NUM_SLOTS];
  bit                    rec_urg      [NUM_SLOTS];

  bit                    sig_live;
  logic [COUNT_W-1:0]    hits;
  logic [COUNT_W-1:0]    entries;
  bit                    sig_dash;
  logic [SIG_NUM_W-1:0]  sig_total;
  bit                    verdict_out;

  // Verdicts the block owes us, oldest first.
  result_t pending_verdicts[$];

  int  error_count     = 0;
  int  items_effective = 0;   // requests other than kind 7 and post-verdict signature items
  bit  sender_calm     = 1'b0;
  bit  sender_rushed   = 1'b0;
  bit  hold_off_toggle = 1'b0;

  function automatic void wipe_match_state();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rec_valid[i]    = 1'b0;
      rec_seq_set[i]  = 1'b0;
      rec_ack_code[i] = '0;
      rec_win[i]      = '0;
      rec_flags[i]    = '0;
      rec_urg[i]      = 1'b0;
    end
    sig_live    = 1'b0;
    hits        = '0;
    entries     = '0;
    sig_dash    = 1'b0;
    sig_total   = '0;
    verdict_out = 1'b0;
  endfunction

  // First reply per slot wins; wrong source port or out-of-range slot drops.
  function automatic void record_reply(in_item_t r);
    logic [PORT_W-1:0] offs;
    logic [SEQ_W-1:0]  sum;
    if (r.src_port != target_port_reg || r.dst_port < base_port_reg) return;
    offs = r.dst_port - base_port_reg;
    if (offs >= NUM_SLOTS || rec_valid[offs]) return;
    sum = r.ack_number - init_seq_reg + 32'(ACK_BASE);
    if (r.ack_number == 0) rec_ack_code[offs] = '0;
    else if (sum > ACK_RANDOM) rec_ack_code[offs] = ACK_CODE_W'(ACK_RANDOM);
    else rec_ack_code[offs] = sum[ACK_CODE_W-1:0];
    rec_seq_set[offs] = (r.seq_number != 0);
    rec_win[offs]     = r.window;
    rec_flags[offs]   = r.tcp_flags;
    rec_urg[offs]     = (r.urgent != 0);
    rec_valid[offs]   = 1'b1;
  endfunction

  function automatic bit entry_agrees(in_item_t e);
    int  s;
    bit  ack_ok;
    bit  win_ok;
    s = e.slot;
    // Slots past the record array never match.
    if (s >= NUM_SLOTS) return 1'b0;
    // No reply in the slot: only an all-zero flag expectation fits.
    if (!rec_valid[s]) return (e.tcp_flags == 0);
    if (e.ack_number >= ACK_BASE) ack_ok = (e.ack_number == rec_ack_code[s]);
    else ack_ok = (e.ack_number == ((rec_ack_code[s] != 0) ? 32'd1 : 32'd0));
    win_ok = (e.window == rec_win[s]) || (e.window == 16'd1 && rec_win[s] != 0);
    return ack_ok && win_ok
        && e.seq_number == (rec_seq_set[s] ? 32'd1 : 32'd0)
        && e.tcp_flags == rec_flags[s]
        && ((e.urgent != 0) == rec_urg[s]);
  endfunction

  function automatic void advance_matcher_model(in_item_t req);
    result_t v;
    if (req.kind == KIND_CLEAR) begin
      items_effective++;
      wipe_match_state();
      return;
    end
    if (req.kind == KIND_REPLY) begin
      items_effective++;
      record_reply(req);
      return;
    end
    // Once a verdict is out, signature items are dead until a clear.
    if (req.kind == KIND_UNUSED || verdict_out) return;
    items_effective++;
    case (req.kind)
      KIND_HEADER: begin
        sig_total = sig_total + 1'b1;
        sig_dash  = req.name_inaccurate;
        sig_live  = 1'b1;
        hits      = '0;
        entries   = '0;
      end
      KIND_ENTRY: begin
        entries = entries + 1'b1;
        if (entry_agrees(req)) begin
          hits = hits + 1'b1;
        end else begin
          hits     = '0;
          sig_live = 1'b0;
        end
      end
      KIND_BLANK: begin
        if (sig_live && hits == entries) begin
          verdict_out        = 1'b1;
          v.verdict          = sig_dash ? VERDICT_INACCURATE : VERDICT_IDENTIFIED;
          v.signature_number = sig_total;
          pending_verdicts.push_back(v);
        end else begin
          sig_live = 1'b0;
          hits     = '0;
          entries  = '0;
        end
      end
      KIND_BAD: begin
        sig_live = 1'b0;
        hits     = '0;
        entries  = '0;
      end
      default: begin
        verdict_out        = 1'b1;
        v.verdict          = VERDICT_UNKNOWN;
        v.signature_number = sig_total;
        pending_verdicts.push_back(v);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: compare each popped result, then draw the next pop stall.
  // --------------------------------------------------------------------------
  result_t want_verdict;
  int      pop_stall     = 0;
  int      hold_off_left = 0;
  bit      hold_off_seen = 1'b0;
  bit      pop_calm      = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result: verdict %0d number %0d", $time,
                   result.verdict, result.signature_number);
          error_count++;
        end else begin
          want_verdict = pending_verdicts.pop_front();
          if (result.verdict !== want_verdict.verdict) begin
            $display("%0t: verdict mismatch: expected %0d actual %0d", $time,
                     want_verdict.verdict, result.verdict);
            error_count++;
          end
          if (result.signature_number !== want_verdict.signature_number) begin
            $display("%0t: signature number mismatch: expected %0d actual %0d",
                     $time, want_verdict.signature_number, result.signature_number);
            error_count++;
          end
        end
        // Switch between stall-free stretches and random stalls now and then.
        if ($urandom_range(0, 15) == 0) pop_calm = !pop_calm;
        pop_stall = pop_calm ? 0 : $urandom_range(0, 12);
      end
      // A toggle from the test process starts a long hold-off.
      if (hold_off_toggle != hold_off_seen) begin
        hold_off_seen = hold_off_toggle;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        pop <= 1'b0;
      end else if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers.
  // --------------------------------------------------------------------------
  task automatic send_request(input in_item_t req);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
    gap = (sender_calm || sender_rushed) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // Keep push high across back-to-back requests; the block takes one per
    // edge while full is low.
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    advance_matcher_model(req);
  endtask

  // Drop push and wait until every owed verdict has been popped.
  task automatic wait_verdicts_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_verdicts_drained();
    // Requests with no result may still be in the pipe; let them retire.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE_PORT:   base_port_reg   = value[PORT_W-1:0];
      CFG_TARGET_PORT: target_port_reg = value[PORT_W-1:0];
      CFG_INIT_SEQ:    init_seq_reg    = value;
      default: ;
    endcase
  endtask

  function automatic in_item_t pack_request(
    logic [2:0] kind, logic [PORT_W-1:0] src, logic [PORT_W-1:0] dst,
    logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack, logic [WIN_W-1:0] win,
    logic [FLAG_W-1:0] flags, logic [PORT_W-1:0] urg, logic [SLOT_W-1:0] slot,
    logic dash);
    in_item_t r;
    r.kind            = kind;
    r.src_port        = src;
    r.dst_port        = dst;
    r.seq_number      = seq;
    r.ack_number      = ack;
    r.window          = win;
    r.tcp_flags       = flags;
    r.urgent          = urg;
    r.slot            = slot;
    r.name_inaccurate = dash;
    return r;
  endfunction

  function automatic in_item_t random_noise();
    return pack_request(3'($urandom), 16'($urandom), 16'($urandom), $urandom,
                        $urandom, 16'($urandom), 8'($urandom), 16'($urandom),
                        4'($urandom), 1'($urandom));
  endfunction

  function automatic in_item_t craft_item(logic [2:0] kind);
    in_item_t r;
    r      = random_noise();
    r.kind = kind;
    return r;
  endfunction

  // Mostly replies that land in a slot, with acks steered toward every code
  // region: zero, exact, saturated and wrapped below the base.
  function automatic in_item_t craft_reply();
    in_item_t r;
    r = craft_item(KIND_REPLY);
    if ($urandom_range(0, 9) < 8) begin
      r.src_port = target_port_reg;
      r.dst_port = base_port_reg + 16'($urandom_range(0, NUM_SLOTS + 1));
    end
    case ($urandom_range(0, 4))
      0: r.ack_number = '0;
      1: r.ack_number = init_seq_reg + $urandom_range(0, 700);
      2: r.ack_number = init_seq_reg - $urandom_range(1, 1500);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) r.seq_number = '0;
    if ($urandom_range(0, 3) == 0) r.window = 16'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) r.tcp_flags = '0;
    if ($urandom_range(0, 1) == 0) r.urgent = '0;
    return r;
  endfunction

  // Build an entry that fits the current record, then spoil it now and then.
  function automatic in_item_t craft_entry();
    in_item_t e;
    int       s;
    e = craft_item(KIND_ENTRY);
    if ($urandom_range(0, 19) == 0) s = $urandom_range(NUM_SLOTS, 15);
    else s = $urandom_range(0, NUM_SLOTS - 1);
    e.slot = s[SLOT_W-1:0];
    if (s < NUM_SLOTS) begin
      if (rec_valid[s]) begin
        e.seq_number = rec_seq_set[s] ? 32'd1 : 32'd0;
        if (rec_ack_code[s] >= ACK_BASE && $urandom_range(0, 1) == 0)
          e.ack_number = 32'(rec_ack_code[s]);
        else
          e.ack_number = (rec_ack_code[s] != 0) ? 32'd1 : 32'd0;
        if (rec_win[s] != 0 && $urandom_range(0, 2) == 0) e.window = 16'd1;
        else e.window = rec_win[s];
        e.tcp_flags = rec_flags[s];
        e.urgent    = rec_urg[s] ? 16'($urandom_range(1, 65535)) : 16'd0;
      end else begin
        e.tcp_flags = '0;
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: e.seq_number = e.seq_number ^ 32'd1;
          1: e.ack_number = e.ack_number + 32'd1;
          2: e.window     = e.window ^ 16'h0002;
          3: e.tcp_flags  = e.tcp_flags ^ 8'h01;
          default: e.urgent = (e.urgent == 0) ? 16'd1 : 16'd0;
        endcase
      end
    end
    return e;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_register_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 5000);
      default: return $urandom;
    endcase
  endfunction

  // One fingerprint run: clear, replies, a few signatures, end marker.
  task automatic run_fingerprint_session();
    int n_replies;
    int n_sigs;
    int n_entries;
    if ($urandom_range(0, 9) != 0) send_request(craft_item(KIND_CLEAR));
    n_replies = $urandom_range(0, 10);
    repeat (n_replies) send_request(craft_reply());
    n_sigs = $urandom_range(1, 5);
    for (int k = 0; k < n_sigs && !verdict_out; k++) begin
      send_request(craft_item(KIND_HEADER));
      n_entries = $urandom_range(0, 6);
      repeat (n_entries) begin
        case ($urandom_range(0, 19))
          0:       send_request(craft_item(KIND_BAD));
          1:       send_request(random_noise());
          2:       send_request(craft_reply());
          default: send_request(craft_entry());
        endcase
      end
      if ($urandom_range(0, 9) != 0) send_request(craft_item(KIND_BLANK));
    end
    if (!verdict_out && $urandom_range(0, 4) != 0) send_request(craft_item(KIND_END));
    // Trailing traffic after a verdict must be ignored.
    if (verdict_out && $urandom_range(0, 3) == 0) send_request(random_noise());
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    logic [PORT_W-1:0] b;
    logic [PORT_W-1:0] t;
    b = BASE_PORT_RESET;
    t = TARGET_PORT_RESET;
    // slot 0: all-ones window, flags and urgent, zero ack
    send_request(pack_request(KIND_REPLY, t, b, '0, '0, '1, '1, '1, '0, 1'b0));
    // wrong source port, slot out of range, below the base port
    send_request(pack_request(KIND_REPLY, t + 16'd1, b + 16'd1, 1, 1, 1, 1, 1, 0, 0));
    send_request(pack_request(KIND_REPLY, t, b + 16'd7, 1, 1, 1, 1, 1, 0, 0));
    send_request(pack_request(KIND_REPLY, t, b - 16'd1, 1, 1, 1, 1, 1, 0, 0));
    // slot 1: ack wraps to a code under the base
    send_request(pack_request(KIND_REPLY, t, b + 16'd1, '1, '1, 16'd1, 8'h12, '0, 0, 0));
    // repeat into slot 0 must not overwrite
    send_request(pack_request(KIND_REPLY, t, b, 32'd5, 32'd9, '0, '0, '0, 0, 0));
    // slot 2 exact random code, slot 6 saturated
    send_request(pack_request(KIND_REPLY, t, b + 16'd2, 32'd1, 32'd666, '0, 8'h10, 16'd3,
                              0, 0));
    send_request(pack_request(KIND_REPLY, t, b + 16'd6, '0, 32'd5000, 16'd9, 8'h04, '0,
                              0, 0));
    send_request(craft_item(KIND_UNUSED));
    send_request(pack_request(KIND_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_request(pack_request(KIND_ENTRY, 0, 0, 32'd0, 32'd0, '1, '1, 16'd5, 4'd0, 0));
    send_request(pack_request(KIND_ENTRY, 0, 0, 32'd1, 32'd1, 16'd1, 8'h12, 16'd0, 4'd1,
                              0));
    send_request(pack_request(KIND_ENTRY, 0, 0, 32'd1, 32'(ACK_RANDOM), 16'd0, 8'h10,
                              16'd1, 4'd2, 0));
    send_request(craft_item(KIND_BLANK));
    // after the verdict: replies still stored, signature items dead
    send_request(pack_request(KIND_REPLY, t, b + 16'd4, 1, 1, 1, 1, 1, 0, 0));
    send_request(craft_item(KIND_HEADER));
    send_request(craft_item(KIND_END));
    send_request(craft_item(KIND_CLEAR));
    // entry slot above the record array fails the signature
    send_request(pack_request(KIND_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_request(pack_request(KIND_ENTRY, 0, 0, 0, 0, 0, 0, 0, 4'd15, 0));
    send_request(craft_item(KIND_BLANK));
    // empty slots: zero flags fit, nonzero flags fail; then a bad line
    send_request(pack_request(KIND_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_request(pack_request(KIND_ENTRY, 0, 0, '1, '1, '1, 8'h00, '1, 4'd5, 0));
    send_request(pack_request(KIND_ENTRY, 0, 0, 0, 0, 0, 8'h01, 0, 4'd6, 0));
    send_request(craft_item(KIND_BAD));
    send_request(pack_request(KIND_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_request(craft_item(KIND_BLANK));
    send_request(craft_item(KIND_CLEAR));
    send_request(craft_item(KIND_END));
    wait_verdicts_drained();
  endtask

  task automatic test_register_extremes();
    write_register(CFG_BASE_PORT, 32'hFFFF_FFFF);
    write_register(CFG_TARGET_PORT, 32'hABCD_0000);
    write_register(CFG_INIT_SEQ, 32'hFFFF_FFFF);
    send_request(craft_item(KIND_CLEAR));
    send_request(pack_request(KIND_REPLY, '0, '1, '1, '0, '1, '1, '1, 0, 0));
    send_request(pack_request(KIND_REPLY, '0, '0, 1, 1, 1, 1, 1, 0, 0));
    repeat (3) run_fingerprint_session();
    write_register(CFG_BASE_PORT, 32'h0000_0000);
    write_register(CFG_TARGET_PORT, 32'h0000_FFFF);
    write_register(CFG_INIT_SEQ, 32'h0000_0000);
    repeat (3) run_fingerprint_session();
    write_register(CFG_UNUSED_INDEX, $urandom);
    repeat (2) run_fingerprint_session();
    write_register(CFG_BASE_PORT, 32'(BASE_PORT_RESET));
    write_register(CFG_TARGET_PORT, 32'(TARGET_PORT_RESET));
    wait_verdicts_drained();
  endtask

  task automatic test_output_backpressure();
    sender_rushed = 1'b1;
    hold_off_toggle <= ~hold_off_toggle;
    // Each clear/header/blank triple yields a verdict; with pop held off the
    // result and command queues fill and full must stall us.
    repeat (10) begin
      send_request(craft_item(KIND_CLEAR));
      send_request(pack_request(KIND_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1'($urandom)));
      send_request(craft_item(KIND_BLANK));
    end
    sender_rushed = 1'b0;
    // Pause the sender until every verdict is back, then carry on.
    wait_verdicts_drained();
    run_fingerprint_session();
    wait_verdicts_drained();
  endtask

  task automatic test_counter_wrap();
    sender_rushed = 1'b1;
    send_request(craft_item(KIND_CLEAR));
    send_request(craft_reply());
    // Run one signature's entry count past 256 so the entries-seen counter wraps.
    send_request(pack_request(KIND_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    repeat (258) send_request(craft_entry());
    send_request(craft_item(KIND_BLANK));
    send_request(craft_item(KIND_END));
    sender_rushed = 1'b0;
    wait_verdicts_drained();
  endtask

  task automatic test_random_sessions();
    int goal;
    int session_no;
    goal       = items_effective + RANDOM_ITEMS;
    session_no = 0;
    while (items_effective < goal) begin
      if (session_no % 6 == 5) begin
        write_register(CFG_BASE_PORT, pick_register_value());
        write_register(CFG_TARGET_PORT, pick_register_value());
        write_register(CFG_INIT_SEQ, pick_register_value());
      end
      run_fingerprint_session();
      session_no++;
    end
    wait_verdicts_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence the run.
  // --------------------------------------------------------------------------
  initial begin
    base_port_reg   = BASE_PORT_RESET;
    target_port_reg = TARGET_PORT_RESET;
    init_seq_reg    = '0;
    wipe_match_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_counter_wrap();
    test_random_sessions();

    wait_verdicts_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (error_count == 0) begin
      $display("[tcp_response_fingerprint_matcher] OK");
    end else begin
      $display("[tcp_response_fingerprint_matcher] ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs on a handshake.
  initial begin
    #(10 * TIMEOUT_CYCLES);
    $display("[tcp_response_fingerprint_matcher] ERROR");
    $finish;
  end

endmodule

// ===== tcp_response_fingerprint_matcher.f =====
+incdir+rtl
rtl/trfm_pkg.sv
rtl/trfm_queue.sv
rtl/trfm_front.sv
rtl/trfm_back.sv
rtl/tcp_response_fingerprint_matcher.sv
dv/tb_tcp_response_fingerprint_matcher.sv
